FILE: rtl/descramble_lzss_window_decoder_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the descrambling LZSS window decoder
// Shared property wrappers; each expands to one labelled concurrent assertion.
// ----------------------------------------------------------------------------
`ifndef DESCRAMBLE_LZSS_WINDOW_DECODER_DEFINES_SVH
`define DESCRAMBLE_LZSS_WINDOW_DECODER_DEFINES_SVH

// same-cycle implication, checked on every clk edge out of reset
`define DLWD_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DLWD_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/dlwd_pkg.sv
// ----------------------------------------------------------------------------
// dlwd_pkg
// Constants shared by the descrambling LZSS window decoder.
// ----------------------------------------------------------------------------
package dlwd_pkg;

    localparam int WINDOW_DEPTH = 4096;
    localparam int WIN_AW       = $clog2(WINDOW_DEPTH);
    localparam int FILL_W       = WIN_AW + 1;
    localparam int REM_W        = 5;

    localparam logic [WIN_AW-1:0] PTR_RESET = WIN_AW'(12'hFEE);
    localparam logic [REM_W-1:0]  LEN_BIAS  = REM_W'(3);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW_DEPTH);

endpackage

FILE: rtl/descramble_lzss_window_decoder.sv
// ----------------------------------------------------------------------------
// descramble_lzss_window_decoder
// Descrambles each input byte by position and decodes LZSS through a
// 4 KiB history window held in a single-port-read synchronous RAM.
// ----------------------------------------------------------------------------
// Flow: a flag byte, a first reference byte or a literal is accepted whenever
// the output is not held. The second byte of a reference starts a copy of 3
// to 18 bytes that runs one byte a cycle through the window RAM's read port
// while the output is not held, with the byte just written forwarded when the
// copy overlaps it; no input is taken until the copy ends. After reset and
// after end_of_block the window reads as zero at once: a fill count marks
// which entries were written, so there is no clearing pass.
`include "descramble_lzss_window_decoder_defines.svh"

module descramble_lzss_window_decoder
    import dlwd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       key_write,
    input  logic [7:0] scramble_key,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       end_of_block,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       last_of_run
);

    typedef enum logic [0:0] {S_IN, S_COPY} state_t;

    state_t              state_reg, state_next;
    logic [7:0]          key_reg;
    logic [7:0]          pos_reg, pos_next;
    logic [8:0]          shift_reg, shift_next;
    logic                ref_high_reg, ref_high_next;
    logic [7:0]          held_reg, held_next;
    logic [WIN_AW-1:0]   ptr_reg, ptr_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [WIN_AW-1:0]   src_reg, src_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic                end_pend_reg, end_pend_next;
    logic                rd_valid_reg, rd_valid_next;
    logic                fwd_hit_reg, fwd_hit_next;
    logic [7:0]          fwd_byte_reg, fwd_byte_next;
    logic                out_valid_reg, out_valid_next;
    logic [7:0]          out_byte_reg, out_byte_next;
    logic                last_reg, last_next;

    logic [7:0]          window_mem [WINDOW_DEPTH];
    logic [7:0]          rdata_reg;
    logic                mem_we;
    logic [WIN_AW-1:0]   mem_waddr;
    logic [7:0]          mem_wdata;
    logic                rd_en;
    logic [WIN_AW-1:0]   rd_addr;
    logic [WIN_AW-1:0]   rd_rel;

    logic                adv;
    logic                accept;
    logic [7:0]          db;
    logic [7:0]          copy_byte;
    logic [WIN_AW-1:0]   ptr_inc;
    logic [FILL_W-1:0]   fill_inc;
    logic                do_clear;

    assign adv       = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IN) && adv;
    assign accept    = in_valid && in_ready;
    assign db        = in_byte ^ (key_reg & pos_reg);
    assign copy_byte = fwd_hit_reg ? fwd_byte_reg : (rd_valid_reg ? rdata_reg : 8'h00);
    assign ptr_inc   = ptr_reg + WIN_AW'(1);
    assign fill_inc  = (fill_reg == FILL_FULL) ? fill_reg : fill_reg + FILL_W'(1);
    assign rd_rel    = rd_addr - PTR_RESET;

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_of_run = last_reg;

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        shift_next     = shift_reg;
        ref_high_next  = ref_high_reg;
        held_next      = held_reg;
        ptr_next       = ptr_reg;
        fill_next      = fill_reg;
        src_next       = src_reg;
        rem_next       = rem_reg;
        end_pend_next  = end_pend_reg;
        fwd_hit_next   = fwd_hit_reg;
        fwd_byte_next  = fwd_byte_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_byte_next  = out_byte_reg;
        last_next      = last_reg;
        mem_we         = 1'b0;
        mem_waddr      = ptr_reg;
        mem_wdata      = 8'h00;
        rd_en          = 1'b0;
        rd_addr        = src_reg;
        do_clear       = 1'b0;

        case (state_reg)
            S_IN:
            begin
                if (accept)
                begin
                    pos_next = pos_reg + 8'd1;
                    if (ref_high_reg)
                    begin
                        rd_addr       = {db[7:4], held_reg};
                        rd_en         = 1'b1;
                        src_next      = rd_addr;
                        rem_next      = REM_W'(db[3:0]) + LEN_BIAS;
                        fwd_hit_next  = 1'b0;
                        shift_next    = shift_reg >> 1;
                        ref_high_next = 1'b0;
                        end_pend_next = end_of_block;
                        state_next    = S_COPY;
                    end
                    else if (shift_reg[8:1] == 8'd0)
                    begin
                        shift_next = {1'b1, db};
                    end
                    else if (shift_reg[0])
                    begin
                        mem_we         = 1'b1;
                        mem_wdata      = db;
                        out_valid_next = 1'b1;
                        out_byte_next  = db;
                        last_next      = 1'b1;
                        ptr_next       = ptr_inc;
                        fill_next      = fill_inc;
                        shift_next     = shift_reg >> 1;
                    end
                    else
                    begin
                        held_next     = db;
                        ref_high_next = 1'b1;
                    end
                    do_clear = end_of_block && !ref_high_reg;
                end
            end
            S_COPY:
            begin
                if (adv)
                begin
                    mem_we         = 1'b1;
                    mem_wdata      = copy_byte;
                    out_valid_next = 1'b1;
                    out_byte_next  = copy_byte;
                    last_next      = (rem_reg == REM_W'(1));
                    ptr_next       = ptr_inc;
                    fill_next      = fill_inc;
                    if (rem_reg == REM_W'(1))
                    begin
                        state_next = S_IN;
                        do_clear   = end_pend_reg;
                    end
                    else
                    begin
                        rd_addr       = src_reg + WIN_AW'(1);
                        rd_en         = 1'b1;
                        src_next      = rd_addr;
                        rem_next      = rem_reg - REM_W'(1);
                        fwd_hit_next  = (rd_addr == ptr_reg);
                        fwd_byte_next = copy_byte;
                    end
                end
            end
            default:
            begin
                state_next = S_IN;
            end
        endcase

        // entry holds data only if written since the last clear
        rd_valid_next = rd_en ? ({1'b0, rd_rel} < fill_reg) : rd_valid_reg;

        if (do_clear)
        begin
            ptr_next      = PTR_RESET;
            fill_next     = '0;
            shift_next    = '0;
            ref_high_next = 1'b0;
            held_next     = 8'h00;
            pos_next      = 8'h00;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IN;
            key_reg       <= 8'hFF;
            pos_reg       <= 8'h00;
            shift_reg     <= '0;
            ref_high_reg  <= 1'b0;
            held_reg      <= 8'h00;
            ptr_reg       <= PTR_RESET;
            fill_reg      <= '0;
            rem_reg       <= '0;
            end_pend_reg  <= 1'b0;
            rd_valid_reg  <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (key_write)
            begin
                key_reg <= scramble_key;
            end
            pos_reg       <= pos_next;
            shift_reg     <= shift_next;
            ref_high_reg  <= ref_high_next;
            held_reg      <= held_next;
            ptr_reg       <= ptr_next;
            fill_reg      <= fill_next;
            rem_reg       <= rem_next;
            end_pend_reg  <= end_pend_next;
            rd_valid_reg  <= rd_valid_next;
            fwd_hit_reg   <= fwd_hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg      <= src_next;
        fwd_byte_reg <= fwd_byte_next;
        out_byte_reg <= out_byte_next;
        last_reg     <= last_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            window_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= window_mem[rd_addr];
        end
    end

    `DLWD_ASSERT_IMP(a_copy_rem, (state_reg == S_COPY), (rem_reg != '0), "copy with no bytes left")
    `DLWD_ASSERT_IMP(a_fill_bound, 1'b1, (fill_reg <= FILL_FULL), "fill count beyond window")
    `DLWD_ASSERT_IMP(a_ptr_fill, !fill_reg[WIN_AW], (ptr_reg == PTR_RESET + fill_reg[WIN_AW-1:0]), "write pointer out of step with fill count")
    `DLWD_ASSERT_NXT(a_copy_last, (state_reg == S_COPY) && adv && (rem_reg == REM_W'(1)), out_valid && last_of_run, "final copy byte not marked last")

endmodule
